>>> src/necir_pkg.sv
// Shared types and constants of the NEC infrared edge decoder.
`default_nettype none
package necir_pkg;

  localparam int unsigned TimeWidth = 20;
  localparam int unsigned WordWidth = 16;
  localparam int unsigned CountWidth = 5;
  localparam int unsigned RegIdxWidth = 3;
  localparam logic [CountWidth-1:0] BitsPerWord = CountWidth'(WordWidth);

  localparam logic [TimeWidth-1:0] ResetOneMin = TimeWidth'(1200);
  localparam logic [TimeWidth-1:0] ResetOneMax = TimeWidth'(2000);
  localparam logic [TimeWidth-1:0] ResetRepStartMin = TimeWidth'(35000);
  localparam logic [TimeWidth-1:0] ResetRepStartMax = TimeWidth'(45000);
  localparam logic [TimeWidth-1:0] ResetBurstMin = TimeWidth'(8000);
  localparam logic [TimeWidth-1:0] ResetGapMin = TimeWidth'(94000);
  localparam logic [TimeWidth-1:0] ResetGapMax = TimeWidth'(100000);
  localparam logic [TimeWidth-1:0] ResetTimeout = TimeWidth'(100000);

  typedef enum logic [2:0] {
    PhIdle     = 3'd0,
    PhSync     = 3'd1,
    PhAddr     = 3'd2,
    PhCmd      = 3'd3,
    PhRepBurst = 3'd4,
    PhRepGap   = 3'd5
  } necir_phase_e;

  typedef enum logic [RegIdxWidth-1:0] {
    RegOneMin      = 3'd0,
    RegOneMax      = 3'd1,
    RegRepStartMin = 3'd2,
    RegRepStartMax = 3'd3,
    RegBurstMin    = 3'd4,
    RegGapMin      = 3'd5,
    RegGapMax      = 3'd6,
    RegTimeout     = 3'd7
  } necir_reg_e;

  typedef enum logic {
    KindEdge    = 1'b0,
    KindTimeout = 1'b1
  } necir_kind_e;

  typedef struct packed {
    logic [TimeWidth-1:0] one_min;
    logic [TimeWidth-1:0] one_max;
    logic [TimeWidth-1:0] rep_start_min;
    logic [TimeWidth-1:0] rep_start_max;
    logic [TimeWidth-1:0] burst_min;
    logic [TimeWidth-1:0] gap_min;
    logic [TimeWidth-1:0] gap_max;
    logic [TimeWidth-1:0] timeout;
  } necir_cfg_t;

  typedef struct packed {
    logic [2:0]            phase;
    logic [WordWidth-1:0]  addr_shift;
    logic [WordWidth-1:0]  cmd_shift;
    logic [CountWidth-1:0] addr_cnt;
    logic [CountWidth-1:0] cmd_cnt;
  } necir_state_t;

  typedef struct packed {
    logic code_valid;
    logic is_repeat;
  } necir_report_t;

endpackage
`default_nettype wire

>>> src/necir_cfg_regs.sv
// Timing window registers of the NEC infrared edge decoder.
`default_nettype none
module necir_cfg_regs (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [necir_pkg::RegIdxWidth-1:0]      cfg_idx_i,
  input  logic [necir_pkg::TimeWidth-1:0]        cfg_wdata_i,
  output necir_pkg::necir_cfg_t                  cfg_o
);

  necir_pkg::necir_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (necir_pkg::necir_reg_e'(cfg_idx_i))
        necir_pkg::RegOneMin:      cfg_d.one_min = cfg_wdata_i;
        necir_pkg::RegOneMax:      cfg_d.one_max = cfg_wdata_i;
        necir_pkg::RegRepStartMin: cfg_d.rep_start_min = cfg_wdata_i;
        necir_pkg::RegRepStartMax: cfg_d.rep_start_max = cfg_wdata_i;
        necir_pkg::RegBurstMin:    cfg_d.burst_min = cfg_wdata_i;
        necir_pkg::RegGapMin:      cfg_d.gap_min = cfg_wdata_i;
        necir_pkg::RegGapMax:      cfg_d.gap_max = cfg_wdata_i;
        necir_pkg::RegTimeout:     cfg_d.timeout = cfg_wdata_i;
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.one_min       <= necir_pkg::ResetOneMin;
      cfg_q.one_max       <= necir_pkg::ResetOneMax;
      cfg_q.rep_start_min <= necir_pkg::ResetRepStartMin;
      cfg_q.rep_start_max <= necir_pkg::ResetRepStartMax;
      cfg_q.burst_min     <= necir_pkg::ResetBurstMin;
      cfg_q.gap_min       <= necir_pkg::ResetGapMin;
      cfg_q.gap_max       <= necir_pkg::ResetGapMax;
      cfg_q.timeout       <= necir_pkg::ResetTimeout;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

>>> src/necir_step.sv
// Next-state and report logic of the NEC decoder for one edge or timeout item.
`default_nettype none
module necir_step (
  input  necir_pkg::necir_cfg_t             cfg_i,
  input  necir_pkg::necir_state_t           state_i,
  input  logic                              kind_i,
  input  logic                              level_i,
  input  logic [necir_pkg::TimeWidth-1:0]   elapsed_us_i,
  output necir_pkg::necir_state_t           state_o,
  output necir_pkg::necir_report_t          report_o
);

  logic is_low;
  logic one_bit;
  logic in_rep_start;
  logic code_ok;
  logic [necir_pkg::CountWidth-1:0] addr_cnt_inc;
  logic [necir_pkg::CountWidth-1:0] cmd_cnt_inc;
  logic [necir_pkg::WordWidth-1:0]  addr_shifted;
  logic [necir_pkg::WordWidth-1:0]  cmd_shifted;

  // A word is good when its high byte is the complement of its low byte.
  function automatic logic word_ok(input logic [necir_pkg::WordWidth-1:0] w);
    word_ok = (w[15:8] == ~w[7:0]);
  endfunction

  assign is_low       = ~level_i;
  assign one_bit      = (elapsed_us_i > cfg_i.one_min) && (elapsed_us_i < cfg_i.one_max);
  assign in_rep_start = (elapsed_us_i > cfg_i.rep_start_min) &&
                        (elapsed_us_i < cfg_i.rep_start_max);
  assign code_ok      = word_ok(state_i.addr_shift) && word_ok(state_i.cmd_shift);
  assign addr_cnt_inc = state_i.addr_cnt + 1'b1;
  assign cmd_cnt_inc  = state_i.cmd_cnt + 1'b1;
  assign addr_shifted = {one_bit, state_i.addr_shift[necir_pkg::WordWidth-1:1]};
  assign cmd_shifted  = {one_bit, state_i.cmd_shift[necir_pkg::WordWidth-1:1]};

  always_comb begin
    state_o  = state_i;
    report_o = '0;
    if (kind_i == necir_pkg::KindTimeout) begin
      if (state_i.phase != necir_pkg::PhIdle && state_i.phase != necir_pkg::PhRepGap &&
          elapsed_us_i > cfg_i.timeout) begin
        state_o.phase = necir_pkg::PhIdle;
      end
    end else begin
      case (state_i.phase)
        necir_pkg::PhIdle: begin
          if (is_low) begin
            if (in_rep_start) begin
              state_o.phase = necir_pkg::PhRepBurst;
            end else begin
              state_o = '0;
              state_o.phase = necir_pkg::PhSync;
            end
          end
        end
        necir_pkg::PhSync: begin
          if (is_low) state_o.phase = necir_pkg::PhAddr;
        end
        necir_pkg::PhAddr: begin
          if (is_low) begin
            state_o.addr_shift = addr_shifted;
            state_o.addr_cnt   = addr_cnt_inc;
            if (addr_cnt_inc >= necir_pkg::BitsPerWord) state_o.phase = necir_pkg::PhCmd;
          end
        end
        necir_pkg::PhCmd: begin
          if (is_low) begin
            state_o.cmd_shift = cmd_shifted;
            state_o.cmd_cnt   = cmd_cnt_inc;
            if (cmd_cnt_inc >= necir_pkg::BitsPerWord) begin
              // The check sees the command word with the last bit shifted in.
              report_o.code_valid = word_ok(state_i.addr_shift) && word_ok(cmd_shifted);
              state_o.phase = necir_pkg::PhIdle;
            end
          end
        end
        necir_pkg::PhRepBurst: begin
          if (!is_low) begin
            if (elapsed_us_i < cfg_i.burst_min) begin
              state_o.phase = necir_pkg::PhIdle;
            end else if (code_ok) begin
              report_o.code_valid = 1'b1;
              report_o.is_repeat  = 1'b1;
            end
          end else begin
            state_o.phase = necir_pkg::PhRepGap;
          end
        end
        necir_pkg::PhRepGap: begin
          if (is_low) begin
            if (elapsed_us_i < cfg_i.gap_min) begin
              state_o.phase = necir_pkg::PhIdle;
            end else if (elapsed_us_i > cfg_i.gap_max) begin
              // A long gap is treated as a falling edge seen from idle.
              if (in_rep_start) begin
                state_o.phase = necir_pkg::PhRepBurst;
              end else begin
                state_o = '0;
                state_o.phase = necir_pkg::PhSync;
              end
            end else begin
              state_o.phase = necir_pkg::PhRepBurst;
            end
          end
        end
        default: state_o.phase = necir_pkg::PhIdle;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> src/nec_ir_edge_decoder.sv
// Top level of the NEC infrared edge decoder: state and result registers.
//
//  channel  direction  handshake               payload
//  in       sink       in_valid_i / in_stall_o  kind, level, elapsed_us
//  out      source     out_valid_o / out_stall_i code_valid, is_repeat,
//                                               address, command, phase
//  cfg      sink       cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// Each item is decoded in the cycle of its transfer and its
// result appears in the output register on the following cycle.
// One item can be taken in every cycle unless the output is stalled; the limit is the single output register.
// in_stall_o is high only while a result is held and the output is stalled.
// Reset returns the window registers to their defaults and the phase to idle.
`default_nettype none
module nec_ir_edge_decoder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                in_kind_i,
  input  logic                                in_level_i,
  input  logic [necir_pkg::TimeWidth-1:0]     in_elapsed_us_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                out_code_valid_o,
  output logic                                out_is_repeat_o,
  output logic [necir_pkg::WordWidth-1:0]     out_address_o,
  output logic [necir_pkg::WordWidth-1:0]     out_command_o,
  output logic [2:0]                          out_phase_o,
  input  logic                                cfg_we_i,
  input  logic [necir_pkg::RegIdxWidth-1:0]   cfg_idx_i,
  input  logic [necir_pkg::TimeWidth-1:0]     cfg_wdata_i
);

  necir_pkg::necir_cfg_t    cfg;
  necir_pkg::necir_state_t  state_q, state_d;
  necir_pkg::necir_report_t report_d, report_q;
  logic                     out_valid_q, out_valid_d;
  logic                     in_xfer;

  necir_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  necir_step u_step (
    .cfg_i        (cfg),
    .state_i      (state_q),
    .kind_i       (in_kind_i),
    .level_i      (in_level_i),
    .elapsed_us_i (in_elapsed_us_i),
    .state_o      (state_d),
    .report_o     (report_d)
  );

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_xfer     = in_valid_i & ~in_stall_o;
  assign out_valid_d = in_xfer | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_xfer) begin
        state_q <= state_d;
      end
    end
  end

  // The reported words and phase are copies of the state after the item.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      report_q <= report_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_code_valid_o = report_q.code_valid;
  assign out_is_repeat_o  = report_q.is_repeat;
  assign out_address_o    = state_q.addr_shift;
  assign out_command_o    = state_q.cmd_shift;
  assign out_phase_o      = state_q.phase;

  a_repeat_needs_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && report_q.is_repeat |-> report_q.code_valid)
    else $error("repeat flag without a reported code");

  a_code_checks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && report_q.code_valid |->
      (state_q.addr_shift[15:8] == ~state_q.addr_shift[7:0]) &&
      (state_q.cmd_shift[15:8] == ~state_q.cmd_shift[7:0]))
    else $error("reported code fails the complement check");

  a_frame_ends_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && report_q.code_valid && !report_q.is_repeat |->
      state_q.phase == necir_pkg::PhIdle)
    else $error("full frame report not followed by idle");

  a_addr_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == necir_pkg::PhAddr |-> state_q.addr_cnt < necir_pkg::BitsPerWord)
    else $error("address bit count overran in address phase");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(state_q))
    else $error("decoder state moved while the result was stalled");

endmodule
`default_nettype wire

>>> dv/nec_ir_decode_checker.sv
// Checker for the NEC infrared edge decoder: predicts every result and compares it.
`timescale 1ns / 100ps
module nec_ir_decode_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic                                in_kind_i,
  input  logic                                in_level_i,
  input  logic [necir_pkg::TimeWidth-1:0]     in_elapsed_us_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic                                out_code_valid_i,
  input  logic                                out_is_repeat_i,
  input  logic [necir_pkg::WordWidth-1:0]     out_address_i,
  input  logic [necir_pkg::WordWidth-1:0]     out_command_i,
  input  logic [2:0]                          out_phase_i,
  input  logic                                cfg_we_i,
  input  logic [necir_pkg::RegIdxWidth-1:0]   cfg_idx_i,
  input  logic [necir_pkg::TimeWidth-1:0]     cfg_wdata_i,
  output int                                  fail_count_o,
  output int                                  outstanding_o
);
  import necir_pkg::*;

  typedef struct packed {
    logic                 code_valid;
    logic                 is_repeat;
    logic [WordWidth-1:0] address;
    logic [WordWidth-1:0] command;
    logic [2:0]           phase;
  } ir_report_t;

  logic [TimeWidth-1:0]  window_us [8];
  necir_phase_e          phase_q;
  logic [WordWidth-1:0]  addr_sr;
  logic [WordWidth-1:0]  cmd_sr;
  logic [CountWidth-1:0] addr_bits;
  logic [CountWidth-1:0] cmd_bits;
  ir_report_t            reports_q [$];
  int                    errors = 0;
  int                    waiting = 0;

  assign fail_count_o = errors;
  assign outstanding_o = waiting;

  function automatic logic word_ok(logic [WordWidth-1:0] w);
    return w[15:8] == ~w[7:0];
  endfunction

  // A gap strictly inside the one window shifts in a one at the top, LSB first.
  function automatic logic [WordWidth-1:0] shift_in(logic [WordWidth-1:0] sr,
                                                    logic [TimeWidth-1:0] t);
    return {(t > window_us[RegOneMin]) && (t < window_us[RegOneMax]), sr[15:1]};
  endfunction

  // A falling edge seen from idle either opens a repeat burst or starts a frame.
  function automatic void idle_fall(logic [TimeWidth-1:0] t);
    if (t > window_us[RegRepStartMin] && t < window_us[RegRepStartMax]) begin
      phase_q = PhRepBurst;
    end else begin
      addr_sr = '0;
      cmd_sr = '0;
      addr_bits = '0;
      cmd_bits = '0;
      phase_q = PhSync;
    end
  endfunction

  function automatic ir_report_t decode_item(logic kind, logic level, logic [TimeWidth-1:0] t);
    ir_report_t r;
    r = '0;
    if (kind == KindTimeout) begin
      if (phase_q != PhIdle && phase_q != PhRepGap && t > window_us[RegTimeout])
        phase_q = PhIdle;
    end else begin
      case (phase_q)
        PhIdle: if (!level) idle_fall(t);
        PhSync: if (!level) phase_q = PhAddr;
        PhAddr: if (!level) begin
          addr_sr = shift_in(addr_sr, t);
          addr_bits = addr_bits + 1'b1;
          if (addr_bits >= BitsPerWord) phase_q = PhCmd;
        end
        PhCmd: if (!level) begin
          cmd_sr = shift_in(cmd_sr, t);
          cmd_bits = cmd_bits + 1'b1;
          if (cmd_bits >= BitsPerWord) begin
            r.code_valid = word_ok(addr_sr) && word_ok(cmd_sr);
            phase_q = PhIdle;
          end
        end
        PhRepBurst: if (level) begin
          if (t < window_us[RegBurstMin]) begin
            phase_q = PhIdle;
          end else if (word_ok(addr_sr) && word_ok(cmd_sr)) begin
            r.code_valid = 1'b1;
            r.is_repeat = 1'b1;
          end
        end else begin
          phase_q = PhRepGap;
        end
        PhRepGap: if (!level) begin
          if (t < window_us[RegGapMin]) phase_q = PhIdle;
          else if (t > window_us[RegGapMax]) idle_fall(t);
          else phase_q = PhRepBurst;
        end
        default: phase_q = PhIdle;
      endcase
    end
    r.address = addr_sr;
    r.command = cmd_sr;
    r.phase = phase_q;
    return r;
  endfunction

  task automatic compare_field(string name, logic [WordWidth-1:0] want,
                               logic [WordWidth-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ir_report_t want;
    if (!rst_ni) begin
      window_us[RegOneMin] = ResetOneMin;
      window_us[RegOneMax] = ResetOneMax;
      window_us[RegRepStartMin] = ResetRepStartMin;
      window_us[RegRepStartMax] = ResetRepStartMax;
      window_us[RegBurstMin] = ResetBurstMin;
      window_us[RegGapMin] = ResetGapMin;
      window_us[RegGapMax] = ResetGapMax;
      window_us[RegTimeout] = ResetTimeout;
      phase_q = PhIdle;
      addr_sr = '0;
      cmd_sr = '0;
      addr_bits = '0;
      cmd_bits = '0;
      reports_q.delete();
      waiting = 0;
    end else begin
      // The result of an item is registered and leaves only after the item, so the output side is checked first.
      if (out_valid_i && !out_stall_i) begin
        if (reports_q.size() == 0) begin
          errors++;
          $display("%0t: result transfer with none expected, got address %0h command %0h",
                   $time, out_address_i, out_command_i);
        end else begin
          want = reports_q.pop_front();
          compare_field("code_valid", want.code_valid, out_code_valid_i);
          compare_field("is_repeat", want.is_repeat, out_is_repeat_i);
          compare_field("address", want.address, out_address_i);
          compare_field("command", want.command, out_command_i);
          compare_field("phase", want.phase, out_phase_i);
        end
      end
      if (in_valid_i && !in_stall_i)
        reports_q.push_back(decode_item(in_kind_i, in_level_i, in_elapsed_us_i));
      if (cfg_we_i) window_us[cfg_idx_i] = cfg_wdata_i;
      waiting = reports_q.size();
    end
  end

endmodule

>>> dv/nec_ir_edge_decoder_tb.sv
// Testbench top for the NEC infrared edge decoder: stimulus, flow control and verdict.
`timescale 1ns / 100ps
module nec_ir_edge_decoder_tb;
  import necir_pkg::*;

  localparam logic [TimeWidth-1:0] TimeMax = '1;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  necir_kind_e          in_kind = KindEdge;
  logic                 in_level = 1'b1;
  logic [TimeWidth-1:0] in_elapsed = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_code_valid;
  logic                 out_is_repeat;
  logic [WordWidth-1:0] out_address;
  logic [WordWidth-1:0] out_command;
  logic [2:0]           out_phase;
  logic                 cfg_we = 1'b0;
  necir_reg_e           cfg_idx = RegOneMin;
  logic [TimeWidth-1:0] cfg_wdata = '0;

  int                   fail_count;
  int                   outstanding;
  int                   items_sent = 0;
  int                   idle_mode = 0;
  logic                 stuck = 1'b0;
  logic                 hold_req = 1'b0;
  logic                 hold_ack = 1'b0;
  int                   hold_left = 0;
  // Current window settings, kept here only to shape the stimulus.
  logic [TimeWidth-1:0] win_us [8] = '{ResetOneMin, ResetOneMax, ResetRepStartMin,
                                       ResetRepStartMax, ResetBurstMin, ResetGapMin,
                                       ResetGapMax, ResetTimeout};

  nec_ir_edge_decoder dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .in_kind_i        (in_kind),
    .in_level_i       (in_level),
    .in_elapsed_us_i  (in_elapsed),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .out_code_valid_o (out_code_valid),
    .out_is_repeat_o  (out_is_repeat),
    .out_address_o    (out_address),
    .out_command_o    (out_command),
    .out_phase_o      (out_phase),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata)
  );

  nec_ir_decode_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_kind_i        (in_kind),
    .in_level_i       (in_level),
    .in_elapsed_us_i  (in_elapsed),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_code_valid_i (out_code_valid),
    .out_is_repeat_i  (out_is_repeat),
    .out_address_i    (out_address),
    .out_command_i    (out_command),
    .out_phase_i      (out_phase),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .fail_count_o     (fail_count),
    .outstanding_o    (outstanding)
  );

  always #6 clk = ~clk;

  initial begin
    #5_000_000;
    $display("FAIL nec_ir_edge_decoder");
    $finish;
  end

  // Receiver side: a requested hold-off stalls the output for a long stretch,
  // otherwise it stalls at random according to the idling mode.
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= 80;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= $urandom_range(99) < ((idle_mode == 0) ? 64 : (idle_mode == 1) ? 13 : 0);
    end
  end

  function automatic logic [TimeWidth-1:0] pick_range(int unsigned lo, int unsigned hi);
    return TimeWidth'($urandom_range(hi, lo));
  endfunction

  // Offers one item and returns at the edge of its transfer; valid stays high
  // unless the sender decides to idle afterwards.
  task automatic send(necir_kind_e kind, logic level, logic [TimeWidth-1:0] t);
    int unsigned idle_pct;
    in_valid <= 1'b1;
    in_kind <= kind;
    in_level <= level;
    in_elapsed <= t;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    items_sent++;
    idle_mode <= (items_sent < 330) ? 0 : (items_sent < 660) ? 1 : 2;
    idle_pct = (idle_mode == 0) ? 13 : (idle_mode == 1) ? 64 : 0;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    if (outstanding != 0) stuck = 1'b1;
    repeat (4) @(posedge clk);
  endtask

  // A full frame: lead burst, sync, 32 bits, then a few repeat bursts. The
  // address and key words carry their complements unless one bit is flipped.
  task automatic send_frame();
    logic [7:0]           addr_byte;
    logic [7:0]           key;
    logic [31:0]          bits;
    logic [TimeWidth-1:0] t;
    int unsigned          roll;
    int                   reps;
    addr_byte = 8'($urandom);
    key = 8'($urandom);
    bits = {~key, key, ~addr_byte, addr_byte};
    if ($urandom_range(7) == 0) bits ^= 32'd1 << $urandom_range(31);
    if ($urandom_range(1)) t = pick_range(win_us[RegRepStartMax], TimeMax);
    else t = pick_range(0, win_us[RegRepStartMin]);
    send(KindEdge, 1'b0, t);
    send(KindEdge, 1'b1, pick_range(8500, 9500));
    send(KindEdge, 1'b0, pick_range(4000, 5000));
    for (int i = 0; i < 32; i++) begin
      roll = $urandom_range(99);
      if (roll < 3) send(KindTimeout, 1'($urandom), pick_range(0, win_us[RegTimeout]));
      else if (roll == 3) send(KindTimeout, 1'($urandom), pick_range(win_us[RegTimeout], TimeMax));
      send(KindEdge, 1'b1, pick_range(450, 650));
      if (bits[i] && win_us[RegOneMax] > win_us[RegOneMin] + 1)
        t = pick_range(win_us[RegOneMin] + 1, win_us[RegOneMax] - 1);
      else if ($urandom_range(1))
        t = pick_range(0, win_us[RegOneMin]);
      else
        t = pick_range(win_us[RegOneMax], TimeMax);
      send(KindEdge, 1'b0, t);
    end
    if (win_us[RegRepStartMax] <= win_us[RegRepStartMin] + 1) return;
    reps = $urandom_range(3);
    for (int r = 0; r < reps; r++) begin
      if (r == 0) t = pick_range(win_us[RegRepStartMin] + 1, win_us[RegRepStartMax] - 1);
      else if (win_us[RegGapMax] >= win_us[RegGapMin])
        t = pick_range(win_us[RegGapMin], win_us[RegGapMax]);
      else break;
      send(KindEdge, 1'b0, t);
      send(KindEdge, 1'b1, pick_range(win_us[RegBurstMin], TimeMax));
      send(KindEdge, 1'b0, pick_range(450, 650));
    end
  endtask

  initial begin
    logic [TimeWidth-1:0] vals [8];
    logic [TimeWidth-1:0] t;
    int unsigned          roll;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed walk through every phase but the command phase with the reset windows.
    send(KindTimeout, 1'b0, TimeMax);
    send(KindEdge, 1'b1, 0);
    send(KindEdge, 1'b0, 0);
    send(KindEdge, 1'b1, TimeMax);
    send(KindTimeout, 1'b1, TimeMax);
    send(KindEdge, 1'b0, 35000);
    send(KindTimeout, 1'b0, 100000);
    send(KindEdge, 1'b0, 4500);
    send(KindEdge, 1'b0, 1200);
    send(KindEdge, 1'b0, 1201);
    send(KindEdge, 1'b0, 1999);
    send(KindEdge, 1'b0, 2000);
    send(KindEdge, 1'b1, 560);
    send(KindTimeout, 1'b0, 100001);
    send(KindEdge, 1'b0, 35001);
    send(KindEdge, 1'b1, 7999);
    send(KindEdge, 1'b0, 44999);
    send(KindEdge, 1'b1, 8000);
    send(KindEdge, 1'b0, 560);
    send(KindEdge, 1'b1, 0);
    send(KindTimeout, 1'b0, TimeMax);
    send(KindEdge, 1'b0, 93999);
    send(KindEdge, 1'b0, 40000);
    send(KindEdge, 1'b0, 0);
    send(KindEdge, 1'b0, 94000);
    send(KindEdge, 1'b0, 0);
    send(KindEdge, 1'b0, 100001);

    for (int p = 0; p < 4; p++) begin
      drain();
      case (p)
        0: vals = '{ResetOneMin, ResetOneMax, ResetRepStartMin, ResetRepStartMax,
                    ResetBurstMin, ResetGapMin, ResetGapMax, ResetTimeout};
        1: vals = '{100, 300, 1000, 3000, 500, 5000, 8000, 20000};
        2: vals = '{0, TimeMax, 0, TimeMax, 0, 0, TimeMax, TimeMax};
        default: vals = '{TimeMax, 0, TimeMax, 0, TimeMax, TimeMax, 0, 0};
      endcase
      // Write enable stays high across the back-to-back register writes.
      for (int r = 0; r < 8; r++) begin
        cfg_we <= 1'b1;
        cfg_idx <= necir_reg_e'(r);
        cfg_wdata <= vals[r];
        win_us[r] = vals[r];
        @(posedge clk);
      end
      cfg_we <= 1'b0;
      hold_req <= ~hold_req;
      while (items_sent < 27 + (p + 1) * 232) begin
        if ($urandom_range(3) != 0) begin
          send_frame();
        end else begin
          for (int n = $urandom_range(6, 1); n > 0; n--) begin
            roll = $urandom_range(3);
            t = (roll == 0) ? '0 : (roll == 1) ? TimeMax : TimeWidth'($urandom);
            send(necir_kind_e'($urandom_range(1)), 1'($urandom), t);
          end
        end
      end
    end
    drain();

    if (fail_count == 0 && !stuck) $display("PASS nec_ir_edge_decoder");
    else $display("FAIL nec_ir_edge_decoder");
    $finish;
  end

endmodule
